/* design/pbpm_pkg.sv */
// Package for the page buffer pool manager: request kinds, status codes,
// defaults. Used by all files in design/.
package pbpm_pkg;
    localparam int POOL_FRAMES_DEF = 16;
    localparam int PAGE_W = 31;
    localparam int PIN_W = 8;

    typedef enum logic [2:0] {
        KIND_FETCH = 3'd0,
        KIND_NEW = 3'd1,
        KIND_DELETE = 3'd2,
        KIND_UNPIN = 3'd3,
        KIND_FLUSH = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NO_FRAME = 3'd1,
        ST_PINNED = 3'd2,
        ST_NOT_RES = 3'd3,
        ST_NOT_PINNED = 3'd4
    } status_t;
endpackage

/* design/page_buffer_pool_manager_core.sv */
// Top level of the page buffer pool manager.
// Depends on pbpm_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  request  | start / busy       | kind, page_number, mark_dirty
//  result   | done (one cycle)   | status, frame_index, page_out,
//           |                    | write_back_*, load_valid, zero_fill,
//           |                    | release_valid
//
// A request is accepted only in idle, so a new one cannot be taken before
// done. Frame state lives in one memory of frame records with a registered
// read; a sequencer makes two sweeps: scan (lookup, LRU victim, evictable
// count), a decision state, apply (read-modify-write of each frame's rank
// and flags), then a result state with done.
// The free queue is a second small memory, read ahead at the next head.
// Reset clears the valid bits per frame (flip-flops) and the queue pointers;
// queue slots read as their own index until written, and a record's flags
// count only while its frame is valid. Results cannot stall.
module page_buffer_pool_manager_core
    import pbpm_pkg::*;
#(
    parameter int POOL_FRAMES = POOL_FRAMES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           kind,
    input  logic [PAGE_W-1:0]    page_number,
    input  logic                 mark_dirty,
    output logic                 done,
    output logic [2:0]           status,
    output logic [3:0]           frame_index,
    output logic [PAGE_W-1:0]    page_out,
    output logic                 write_back_valid,
    output logic [PAGE_W-1:0]    write_back_page,
    output logic                 load_valid,
    output logic                 zero_fill,
    output logic                 release_valid
);
    localparam int FW = $clog2(POOL_FRAMES);
    localparam int CW = $clog2(POOL_FRAMES + 1);

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PIN_W-1:0]  pins;
        logic              dirty;
        logic              evict;
        logic [FW-1:0]     rank;
    } frame_rec_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DEC   = 5'b00100,
        S_APPLY = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    frame_rec_t mem [POOL_FRAMES];
    frame_rec_t rd_q;
    logic [FW-1:0] fq_mem [POOL_FRAMES];
    logic [POOL_FRAMES-1:0] fq_wr_reg;
    logic [POOL_FRAMES-1:0] valid_reg;

    logic [FW-1:0] head_reg, head_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;

    // request
    logic [2:0] kind_reg;
    logic [PAGE_W-1:0] page_reg;
    logic dirty_in_reg;

    // sweep
    logic [CW-1:0] rd_idx_reg, rd_idx_next;  // read address, one ahead
    logic [FW-1:0] cur_reg, cur_next;        // entry whose data is in rd_q
    logic          cur_v_reg, cur_v_next;

    // scan results
    logic          hit_reg, hit_next;
    logic [FW-1:0] hit_f_reg, hit_f_next;
    frame_rec_t    hit_rec_reg, hit_rec_next;
    logic          vic_reg, vic_next;
    logic [FW-1:0] vic_f_reg, vic_f_next;
    frame_rec_t    vic_rec_reg, vic_rec_next;
    logic          vic_valid_reg, vic_valid_next;
    logic [CW-1:0] nevict_reg, nevict_next;

    // decisions
    logic          tgt_reg, tgt_next;          // a frame is updated
    logic [FW-1:0] tgt_f_reg, tgt_f_next;
    frame_rec_t    tgt_rec_reg, tgt_rec_next;   // its new record
    logic          tgt_valid_reg, tgt_valid_next;
    logic          rm_reg, rm_next;             // rank removal happens
    logic [FW-1:0] rm_rank_reg, rm_rank_next;
    logic          rm2_reg, rm2_next;           // second removal: dropped copy
    logic [FW-1:0] rm2_rank_reg, rm2_rank_next;
    logic          dup_reg, dup_next;           // drop other copies (new)
    logic [FW-1:0] fq_tail_reg;
    logic [CW-1:0] fcnt_w_reg;

    // result
    logic [2:0]  st_reg, st_next;
    logic [3:0]  fi_reg, fi_next;
    logic        wb_reg, wb_next;
    logic [PAGE_W-1:0] wbp_reg, wbp_next;
    logic        ld_reg, ld_next, zf_reg, zf_next, rl_reg, rl_next;

    logic [FW-1:0] fq_rd_q;
    logic          fq_wr_en;
    logic [FW-1:0] fq_wr_addr, fq_wr_data;

    logic          mem_we;
    logic [FW-1:0] mem_wa;
    frame_rec_t    mem_wd;
    logic          vset, vclr;
    logic [FW-1:0] rd_addr;
    logic [FW-1:0] head_rd;

    assign rd_addr = rd_idx_reg[FW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q <= mem[rd_addr];
    end

    // free queue memory; unwritten slots read as their own index
    assign head_rd = (state_reg == S_IDLE) ? head_reg : head_next;
    always_ff @(posedge clk)
    begin
        if (fq_wr_en)
        begin
            fq_mem[fq_wr_addr] <= fq_wr_data;
        end
        fq_rd_q <= fq_mem[head_rd];
    end

    logic fq_rd_w_reg;
    logic [FW-1:0] fq_rd_a_reg;
    logic [FW-1:0] fq_head_val;
    always_ff @(posedge clk)
    begin
        fq_rd_a_reg <= head_rd;
    end
    assign fq_head_val = fq_wr_reg[fq_rd_a_reg] ? fq_rd_q : fq_rd_a_reg;
    assign fq_rd_w_reg = 1'b0;

    // queue tail: head + count, wrapped by one compare and subtract
    logic [CW:0]   tail_sum, tail_dec_sum;
    logic [FW-1:0] tail, tail_dec;
    assign tail_sum = (CW+1)'(head_reg) + (CW+1)'(fcnt_reg);
    assign tail = (tail_sum >= (CW+1)'(POOL_FRAMES)) ?
        FW'(tail_sum - (CW+1)'(POOL_FRAMES)) : FW'(tail_sum);
    assign tail_dec_sum = (CW+1)'(head_next) + (CW+1)'(fcnt_next);
    assign tail_dec = (tail_dec_sum >= (CW+1)'(POOL_FRAMES)) ?
        FW'(tail_dec_sum - (CW+1)'(POOL_FRAMES)) : FW'(tail_dec_sum);

    // registered view of the current entry
    frame_rec_t cur_rec;
    logic       cur_valid;
    assign cur_rec = rd_q;
    assign cur_valid = valid_reg[cur_reg];

    logic last_rd;
    assign last_rd = (rd_idx_reg == CW'(POOL_FRAMES - 1));

    // ranks above a removed rank shift down once per removal
    logic rm_hit, rm2_hit;
    assign rm_hit = rm_reg && (cur_rec.rank > rm_rank_reg);
    assign rm2_hit = rm2_reg && (cur_rec.rank > rm2_rank_reg);

    always_comb
    begin
        state_next = state_reg;
        rd_idx_next = rd_idx_reg;
        cur_next = cur_reg;
        cur_v_next = 1'b0;
        hit_next = hit_reg;
        hit_f_next = hit_f_reg;
        hit_rec_next = hit_rec_reg;
        vic_next = vic_reg;
        vic_f_next = vic_f_reg;
        vic_rec_next = vic_rec_reg;
        vic_valid_next = vic_valid_reg;
        nevict_next = nevict_reg;
        tgt_next = tgt_reg;
        tgt_f_next = tgt_f_reg;
        tgt_rec_next = tgt_rec_reg;
        tgt_valid_next = tgt_valid_reg;
        rm_next = rm_reg;
        rm_rank_next = rm_rank_reg;
        rm2_next = rm2_reg;
        rm2_rank_next = rm2_rank_reg;
        dup_next = dup_reg;
        st_next = st_reg;
        fi_next = fi_reg;
        wb_next = wb_reg;
        wbp_next = wbp_reg;
        ld_next = ld_reg;
        zf_next = zf_reg;
        rl_next = rl_reg;
        head_next = head_reg;
        fcnt_next = fcnt_reg;
        mem_we = 1'b0;
        mem_wa = cur_reg;
        mem_wd = cur_rec;
        vset = 1'b0;
        vclr = 1'b0;
        fq_wr_en = 1'b0;
        fq_wr_addr = tail;
        fq_wr_data = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    rd_idx_next = CW'(1);
                    cur_next = '0;
                    cur_v_next = 1'b1;
                    hit_next = 1'b0;
                    vic_next = 1'b0;
                    nevict_next = '0;
                    hit_f_next = '0;
                    vic_f_next = '0;
                end
            end
            S_SCAN:
            begin
                if (cur_v_reg)
                begin
                    if (!hit_reg && cur_valid && cur_rec.page == page_reg)
                    begin
                        hit_next = 1'b1;
                        hit_f_next = cur_reg;
                        hit_rec_next = cur_rec;
                    end
                    if (cur_valid && cur_rec.evict)
                    begin
                        nevict_next = nevict_reg + CW'(1);
                        if (!vic_reg && cur_rec.rank == '0)
                        begin
                            vic_next = 1'b1;
                            vic_f_next = cur_reg;
                            vic_rec_next = cur_rec;
                            vic_valid_next = cur_valid;
                        end
                    end
                    if (cur_reg == FW'(POOL_FRAMES - 1))
                    begin
                        state_next = S_DEC;
                    end
                    else
                    begin
                        cur_next = cur_reg + FW'(1);
                        cur_v_next = 1'b1;
                        rd_idx_next = last_rd ? '0 : rd_idx_reg + CW'(1);
                    end
                end
            end
            S_DEC:
            begin
                st_next = ST_OK;
                fi_next = '0;
                wb_next = 1'b0;
                wbp_next = '0;
                ld_next = 1'b0;
                zf_next = 1'b0;
                rl_next = 1'b0;
                tgt_next = 1'b0;
                rm_next = 1'b0;
                rm_rank_next = '0;
                rm2_next = 1'b0;
                rm2_rank_next = '0;
                dup_next = 1'b0;
                tgt_f_next = hit_f_reg;
                tgt_rec_next = hit_rec_reg;
                tgt_valid_next = 1'b1;
                if ((kind_reg == KIND_FETCH && !hit_reg) || kind_reg == KIND_NEW)
                begin
                    if (fcnt_reg != '0)
                    begin
                        tgt_next = 1'b1;
                        tgt_f_next = fq_head_val;
                        head_next = (head_reg == FW'(POOL_FRAMES - 1)) ?
                            '0 : head_reg + FW'(1);
                        fcnt_next = fcnt_reg - CW'(1);
                    end
                    else if (vic_reg)
                    begin
                        tgt_next = 1'b1;
                        tgt_f_next = vic_f_reg;
                        rm_next = 1'b1;
                        rm_rank_next = vic_rec_reg.rank;
                        if (vic_valid_reg && vic_rec_reg.dirty)
                        begin
                            wb_next = 1'b1;
                            wbp_next = vic_rec_reg.page;
                        end
                    end
                    else
                    begin
                        st_next = ST_NO_FRAME;
                    end
                    tgt_rec_next.page = page_reg;
                    tgt_rec_next.pins = PIN_W'(1);
                    tgt_rec_next.dirty = 1'b0;
                    tgt_rec_next.evict = 1'b0;
                    tgt_rec_next.rank = '0;
                    fi_next = 4'(tgt_f_next);
                    if (kind_reg == KIND_NEW)
                    begin
                        zf_next = tgt_next;
                        dup_next = tgt_next;
                        // the resident copy (at most one) leaves the LRU set
                        rm2_next = tgt_next && hit_reg && hit_rec_reg.evict &&
                            (hit_f_reg != tgt_f_next);
                        rm2_rank_next = hit_rec_reg.rank;
                    end
                    else
                    begin
                        ld_next = tgt_next;
                    end
                    if (!tgt_next)
                    begin
                        fi_next = '0;
                    end
                end
                else
                begin
                    unique case (kind_reg)
                        KIND_FETCH:
                        begin
                            tgt_next = 1'b1;
                            fi_next = 4'(hit_f_reg);
                            if (hit_rec_reg.pins != '1)
                            begin
                                tgt_rec_next.pins = hit_rec_reg.pins + PIN_W'(1);
                            end
                            tgt_rec_next.evict = 1'b0;
                            tgt_rec_next.rank = '0;
                            rm_next = hit_rec_reg.evict;
                            rm_rank_next = hit_rec_reg.rank;
                        end
                        KIND_DELETE:
                        begin
                            if (!hit_reg)
                            begin
                                rl_next = 1'b1;
                            end
                            else if (hit_rec_reg.pins != '0)
                            begin
                                st_next = ST_PINNED;
                            end
                            else
                            begin
                                tgt_next = 1'b1;
                                tgt_valid_next = 1'b0;
                                fi_next = 4'(hit_f_reg);
                                rl_next = 1'b1;
                                wb_next = hit_rec_reg.dirty;
                                wbp_next = hit_rec_reg.dirty ? page_reg : '0;
                                tgt_rec_next = '0;
                                rm_next = hit_rec_reg.evict;
                                rm_rank_next = hit_rec_reg.rank;
                            end
                        end
                        KIND_UNPIN:
                        begin
                            if (!hit_reg)
                            begin
                                st_next = ST_NOT_RES;
                            end
                            else
                            begin
                                fi_next = 4'(hit_f_reg);
                                if (hit_rec_reg.pins == '0)
                                begin
                                    st_next = ST_NOT_PINNED;
                                end
                                else
                                begin
                                    tgt_next = 1'b1;
                                    tgt_rec_next.pins = hit_rec_reg.pins - PIN_W'(1);
                                    if (dirty_in_reg)
                                    begin
                                        tgt_rec_next.dirty = 1'b1;
                                    end
                                    if (hit_rec_reg.pins == PIN_W'(1) &&
                                        !hit_rec_reg.evict)
                                    begin
                                        tgt_rec_next.evict = 1'b1;
                                        tgt_rec_next.rank = FW'(nevict_reg);
                                    end
                                end
                            end
                        end
                        KIND_FLUSH:
                        begin
                            if (!hit_reg)
                            begin
                                st_next = ST_NOT_RES;
                            end
                            else
                            begin
                                fi_next = 4'(hit_f_reg);
                                wb_next = 1'b1;
                                wbp_next = page_reg;
                                tgt_next = 1'b1;
                                tgt_rec_next.dirty = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                state_next = S_APPLY;
                rd_idx_next = CW'(1);
                cur_next = '0;
                cur_v_next = 1'b1;
            end
            S_APPLY:
            begin
                // per-frame rewrite: target record, rank shift, dup drop
                mem_wa = cur_reg;
                mem_wd = cur_rec;
                if (tgt_reg && cur_reg == tgt_f_reg)
                begin
                    mem_we = 1'b1;
                    mem_wd = tgt_rec_reg;
                    if (tgt_valid_reg)
                    begin
                        vset = 1'b1;
                    end
                    else
                    begin
                        vclr = 1'b1;
                        fq_wr_en = fcnt_w_reg < CW'(POOL_FRAMES);
                        fq_wr_addr = fq_tail_reg;
                        if (fq_wr_en)
                        begin
                            fcnt_next = fcnt_reg + CW'(1);
                        end
                    end
                end
                else if (dup_reg && cur_valid && cur_rec.page == page_reg)
                begin
                    // drop other copy; its rank removal is rm2
                    mem_we = 1'b1;
                    mem_wd = '0;
                    vclr = 1'b1;
                    fq_wr_en = fcnt_w_reg < CW'(POOL_FRAMES);
                    fq_wr_addr = fq_tail_reg;
                    if (fq_wr_en)
                    begin
                        fcnt_next = fcnt_reg + CW'(1);
                    end
                end
                else if (cur_valid && cur_rec.evict && (rm_hit || rm2_hit))
                begin
                    mem_we = 1'b1;
                    mem_wd.rank = cur_rec.rank - FW'(rm_hit) - FW'(rm2_hit);
                end
                if (cur_reg == FW'(POOL_FRAMES - 1))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cur_next = cur_reg + FW'(1);
                    cur_v_next = 1'b1;
                    rd_idx_next = last_rd ? '0 : rd_idx_reg + CW'(1);
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
                rd_idx_next = '0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Duplicate drop on new: at most one other frame holds the page, and the
    // scan hit names it. When it is evictable its rank is removed as well as
    // the victim's; each entry drops by the number of removed ranks below
    // it, both compared against the ranks read in this sweep.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            fq_wr_reg <= '0;
            head_reg <= '0;
            fcnt_reg <= CW'(POOL_FRAMES);
            rd_idx_reg <= '0;
            cur_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_idx_reg <= rd_idx_next;
            cur_v_reg <= cur_v_next;
            head_reg <= head_next;
            fcnt_reg <= fcnt_next;
            if (vset)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            if (vclr)
            begin
                valid_reg[mem_wa] <= 1'b0;
            end
            if (fq_wr_en)
            begin
                fq_wr_reg[fq_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            page_reg <= page_number;
            dirty_in_reg <= mark_dirty;
        end
        cur_reg <= cur_next;
        hit_reg <= hit_next;
        hit_f_reg <= hit_f_next;
        hit_rec_reg <= hit_rec_next;
        vic_reg <= vic_next;
        vic_f_reg <= vic_f_next;
        vic_rec_reg <= vic_rec_next;
        vic_valid_reg <= vic_valid_next;
        nevict_reg <= nevict_next;
        tgt_reg <= tgt_next;
        tgt_f_reg <= tgt_f_next;
        tgt_rec_reg <= tgt_rec_next;
        tgt_valid_reg <= tgt_valid_next;
        rm_reg <= rm_next;
        rm_rank_reg <= rm_rank_next;
        rm2_reg <= rm2_next;
        rm2_rank_reg <= rm2_rank_next;
        dup_reg <= dup_next;
        st_reg <= st_next;
        fi_reg <= fi_next;
        wb_reg <= wb_next;
        wbp_reg <= wbp_next;
        ld_reg <= ld_next;
        zf_reg <= zf_next;
        rl_reg <= rl_next;
        if (state_reg == S_DEC)
        begin
            fq_tail_reg <= tail_dec;
            fcnt_w_reg <= fcnt_next;
        end
        else if (fq_wr_en)
        begin
            fq_tail_reg <= (fq_tail_reg == FW'(POOL_FRAMES - 1)) ?
                '0 : fq_tail_reg + FW'(1);
            fcnt_w_reg <= fcnt_w_reg + CW'(1);
        end
    end

    assign busy = (state_reg != S_IDLE) || fq_rd_w_reg;
    assign done = (state_reg == S_OUT);
    assign status = st_reg;
    assign frame_index = fi_reg;
    assign page_out = page_reg;
    assign write_back_valid = wb_reg;
    assign write_back_page = wbp_reg;
    assign load_valid = ld_reg;
    assign zero_fill = zf_reg;
    assign release_valid = rl_reg;
endmodule

/* verif/page_buffer_pool_manager_checker.sv */
// Checker for the page buffer pool manager: predicts every result from the
// accepted request beats and compares them with the done beats.
// Depends on pbpm_pkg.
module page_buffer_pool_manager_checker
    import pbpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [2:0]        kind,
    input  logic [PAGE_W-1:0] page_number,
    input  logic              mark_dirty,
    input  logic              done,
    input  logic [2:0]        status,
    input  logic [3:0]        frame_index,
    input  logic [PAGE_W-1:0] page_out,
    input  logic              write_back_valid,
    input  logic [PAGE_W-1:0] write_back_page,
    input  logic              load_valid,
    input  logic              zero_fill,
    input  logic              release_valid,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = POOL_FRAMES_DEF;

    typedef struct {
        logic [2:0]        st;
        logic [3:0]        frame;
        logic [PAGE_W-1:0] page;
        logic              wb;
        logic [PAGE_W-1:0] wb_page;
        logic              load;
        logic              zero;
        logic              rel;
    } pool_result_t;

    // mirror of the frame table
    logic [PAGE_W-1:0] pg    [NF];
    logic              vld   [NF];
    logic [7:0]        pins  [NF];
    logic              dirty [NF];
    logic              evict [NF];
    int                rank  [NF];
    int                fq    [NF];
    int                fq_head, fq_count;

    pool_result_t awaited[$];

    assign pending = awaited.size();

    function automatic int find_page(logic [PAGE_W-1:0] p);
        for (int i = 0; i < NF; i++)
            if (vld[i] && pg[i] == p) return i;
        return -1;
    endfunction

    function automatic void lru_drop(int f);
        if (!evict[f]) return;
        for (int i = 0; i < NF; i++)
            if (evict[i] && rank[i] > rank[f]) rank[i]--;
        evict[f] = 0;
        rank[f] = 0;
    endfunction

    function automatic void lru_join(int f);
        int n;
        n = 0;
        if (evict[f]) return;
        for (int i = 0; i < NF; i++)
            if (evict[i]) n++;
        rank[f] = n;
        evict[f] = 1;
    endfunction

    function automatic void release_frame(int f);
        lru_drop(f);
        vld[f] = 0;
        pins[f] = 0;
        dirty[f] = 0;
        pg[f] = '0;
    endfunction

    function automatic void push_free(int f);
        if (fq_count < NF) begin
            fq[(fq_head + fq_count) % NF] = f;
            fq_count++;
        end
    endfunction

    // free queue first, else LRU rank 0; a dirty victim is written back
    function automatic int grab_frame(ref pool_result_t r);
        int f;
        if (fq_count > 0) begin
            f = fq[fq_head];
            fq_head = (fq_head + 1) % NF;
            fq_count--;
            return f;
        end
        for (int i = 0; i < NF; i++)
            if (evict[i] && rank[i] == 0) begin
                if (vld[i] && dirty[i]) begin
                    r.wb = 1;
                    r.wb_page = pg[i];
                end
                release_frame(i);
                return i;
            end
        return -1;
    endfunction

    function automatic void seat_page(int f, logic [PAGE_W-1:0] p);
        pg[f] = p;
        vld[f] = 1;
        pins[f] = 1;
        dirty[f] = 0;
        lru_drop(f);
    endfunction

    function automatic pool_result_t serve_request(logic [2:0] k, logic [PAGE_W-1:0] p,
                                                   logic d);
        pool_result_t r;
        int f;
        r = '{st: ST_OK, frame: 0, page: p, wb: 0, wb_page: 0, load: 0, zero: 0, rel: 0};
        case (k)
            KIND_FETCH: begin
                f = find_page(p);
                if (f >= 0) begin
                    if (pins[f] != 8'd255) pins[f]++;
                    lru_drop(f);
                    r.frame = f[3:0];
                end else begin
                    f = grab_frame(r);
                    if (f < 0) r.st = ST_NO_FRAME;
                    else begin
                        seat_page(f, p);
                        r.load = 1;
                        r.frame = f[3:0];
                    end
                end
            end
            KIND_NEW: begin
                f = grab_frame(r);
                if (f < 0) r.st = ST_NO_FRAME;
                else begin
                    // stale copies of the same page are dropped silently
                    for (int i = 0; i < NF; i++)
                        if (i != f && vld[i] && pg[i] == p) begin
                            release_frame(i);
                            push_free(i);
                        end
                    seat_page(f, p);
                    r.frame = f[3:0];
                    r.zero = 1;
                end
            end
            KIND_DELETE: begin
                f = find_page(p);
                if (f < 0) r.rel = 1;
                else if (pins[f] > 0) r.st = ST_PINNED;
                else begin
                    if (dirty[f]) begin
                        r.wb = 1;
                        r.wb_page = p;
                    end
                    release_frame(f);
                    push_free(f);
                    r.frame = f[3:0];
                    r.rel = 1;
                end
            end
            KIND_UNPIN: begin
                f = find_page(p);
                if (f < 0) r.st = ST_NOT_RES;
                else begin
                    r.frame = f[3:0];
                    if (pins[f] == 0) r.st = ST_NOT_PINNED;
                    else begin
                        pins[f]--;
                        if (d) dirty[f] = 1;
                        if (pins[f] == 0) lru_join(f);
                    end
                end
            end
            KIND_FLUSH: begin
                f = find_page(p);
                if (f < 0) r.st = ST_NOT_RES;
                else begin
                    r.frame = f[3:0];
                    r.wb = 1;
                    r.wb_page = p;
                    dirty[f] = 0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pool_result_t e;
        if (!rst_n) begin
            for (int i = 0; i < NF; i++) begin
                pg[i] = '0;
                vld[i] = 0;
                pins[i] = 0;
                dirty[i] = 0;
                evict[i] = 0;
                rank[i] = 0;
                fq[i] = i;
            end
            fq_head = 0;
            fq_count = NF;
            errors = 0;
            awaited.delete();
        end else begin
            if (start && !busy)
                awaited.insert(awaited.size(), serve_request(kind, page_number, mark_dirty));
            if (done) begin
                if (awaited.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    errors++;
                end else begin
                    e = awaited[0];
                    awaited.delete(0);
                    if ({status, frame_index, page_out, write_back_valid, write_back_page,
                         load_valid, zero_fill, release_valid} !==
                        {e.st, e.frame, e.page, e.wb, e.wb_page, e.load, e.zero, e.rel}) begin
                        $display("%0t: mismatch exp st=%0d fr=%0d pg=%h wb=%0b/%h ld=%0b zf=%0b rl=%0b",
                                 $time, e.st, e.frame, e.page, e.wb, e.wb_page, e.load,
                                 e.zero, e.rel);
                        $display("%0t:          got st=%0d fr=%0d pg=%h wb=%0b/%h ld=%0b zf=%0b rl=%0b",
                                 $time, status, frame_index, page_out, write_back_valid,
                                 write_back_page, load_valid, zero_fill, release_valid);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

/* verif/page_buffer_pool_manager_core_tb.sv */
// Testbench top for the page buffer pool manager: clock, reset and request
// stimulus; checking lives in page_buffer_pool_manager_checker.
// Depends on pbpm_pkg, the core and the checker.
module page_buffer_pool_manager_core_tb;
    import pbpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;   // watchdog bound, far above what the ~600 request beats need
    localparam int TAIL_CYCLES = 120;      // idle tail after the last result

    logic              clk, rst_n, start, busy, done;
    logic [2:0]        kind;
    logic [PAGE_W-1:0] page_number;
    logic              mark_dirty;
    logic [2:0]        status;
    logic [3:0]        frame_index;
    logic [PAGE_W-1:0] page_out, write_back_page;
    logic              write_back_valid, load_valid, zero_fill, release_valid;
    int                errors, pending, cycles;
    bit                gaps_on;

    page_buffer_pool_manager_core uut (.*);
    page_buffer_pool_manager_checker chk (.*);

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One request beat. Called and returns at a falling edge; start stays
    // high straight into the next beat unless a gap is drawn.
    task automatic send_req(logic [2:0] k, logic [PAGE_W-1:0] p, logic d);
        if (gaps_on && $urandom_range(99) < 13) begin
            start <= 0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
        kind <= k;
        page_number <= p;
        mark_dirty <= d;
        start <= 1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // small page pool so hits, evictions and stale copies are frequent
    function automatic logic [PAGE_W-1:0] pick_page();
        if ($urandom_range(99) < 8)
            return PAGE_W'($urandom());
        return PAGE_W'($urandom_range(23));
    endfunction

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 35) return KIND_FETCH;
        if (r < 45) return KIND_NEW;
        if (r < 55) return KIND_DELETE;
        if (r < 86) return KIND_UNPIN;
        if (r < 97) return KIND_FLUSH;
        return 3'($urandom_range(7, 5));   // undefined kinds
    endfunction

    initial begin
        cycles = 0;
        gaps_on = 1;
        start = 0;
        kind = KIND_FETCH;
        page_number = '0;
        mark_dirty = 0;
        rst_n = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // pin count saturation: 258 fetches of one page, then a new of the
        // same page drops the saturated frame back into the free queue
        for (int i = 0; i < 258; i++) send_req(KIND_FETCH, 31'd42, 0);
        send_req(KIND_UNPIN, 31'd42, 1);
        send_req(KIND_NEW, 31'd42, 0);
        send_req(KIND_UNPIN, 31'd42, 0);
        send_req(KIND_DELETE, 31'd42, 0);

        // directed: fill every frame, run out, evict dirty, corner statuses
        for (int i = 0; i < 16; i++) send_req(KIND_FETCH, PAGE_W'(i), 0);
        send_req(KIND_FETCH, 31'd16, 0);            // no frame
        send_req(KIND_NEW, 31'd100, 0);             // no frame
        send_req(KIND_UNPIN, 31'd3, 1);             // dirty, evictable
        send_req(KIND_FETCH, 31'h7FFF_FFFF, 0);     // evicts page 3 with write back
        send_req(KIND_UNPIN, 31'd1, 0);
        send_req(KIND_UNPIN, 31'd1, 0);             // not pinned
        send_req(KIND_NEW, 31'd0, 0);               // new on resident page
        send_req(KIND_DELETE, 31'd4, 0);            // pinned
        send_req(KIND_DELETE, 31'h5555_5555, 0);    // absent
        send_req(KIND_FLUSH, 31'd5, 0);
        send_req(KIND_FLUSH, 31'h2AAA_AAAA, 0);     // not resident
        send_req(KIND_UNPIN, 31'd77, 1);            // not resident
        send_req(3'd7, 31'd5, 1);                   // undefined kind

        // random; the middle stretch runs back to back with no gaps
        for (int i = 0; i < 310; i++) begin
            gaps_on = !(i >= 100 && i < 200);
            send_req(pick_kind(), pick_page(), 1'($urandom_range(1)));
        end
        start <= 0;

        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sim.f */
design/pbpm_pkg.sv
design/page_buffer_pool_manager_core.sv
verif/page_buffer_pool_manager_checker.sv
verif/page_buffer_pool_manager_core_tb.sv
